### rtl/kslp_pkg.sv
// Shared types, constants and helpers for the key press / LED mode block.
// No dependencies; used by kslp_led and key_short_long_press_led_modes.
`timescale 1ns / 1ps
`default_nettype none

package kslp_pkg;

  localparam int unsigned CntW = 16;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BLINK_MAX  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLINK_LOW  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CntW-1:0] LONG_PRESS_RST = 16'd3000;
  localparam logic [CntW-1:0] BLINK_MAX_RST  = 16'd1000;
  localparam logic [CntW-1:0] BLINK_LOW_RST  = 16'd500;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_TIMING  = 2'd2,
    PH_WAIT    = 2'd3
  } key_phase_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } key_event_e;

  typedef enum logic [1:0] {
    MODE_SET   = 2'd0,
    MODE_RESET = 2'd1,
    MODE_BLINK = 2'd2
  } led_mode_e;

  typedef struct packed {
    logic [CntW-1:0] period_max;
    logic [CntW-1:0] low_ticks;
  } blink_cfg_t;

  // set -> reset -> blink -> set
  function automatic led_mode_e next_mode(input led_mode_e m);
    led_mode_e n;
    unique case (m)
      MODE_SET:   n = MODE_RESET;
      MODE_RESET: n = MODE_BLINK;
      default:    n = MODE_SET;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/kslp_if.sv
// Valid/ready channel interfaces: key sample input and per-tick result output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface kslp_in_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink   (input valid, input key_level, output ready);
endinterface

interface kslp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_event;
  logic       led1_level;
  logic       led2_level;
  logic [1:0] led1_mode;
  logic [1:0] led2_mode;

  modport source (output valid, output key_event, output led1_level, output led2_level,
                  output led1_mode, output led2_mode, input ready);
  modport sink   (input valid, input key_event, input led1_level, input led2_level,
                  input led1_mode, input led2_mode, output ready);
endinterface

`default_nettype wire

### rtl/kslp_led.sv
// One LED channel: mode register, blink counter and pin level.
// Depends on kslp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kslp_led
  import kslp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       advance_i,  // tick taken this cycle
  input  wire logic       step_i,     // press event for this LED
  input  wire blink_cfg_t cfg_i,
  output      led_mode_e  mode_o,     // mode after this tick
  output      logic       level_o     // level for this tick
);

  led_mode_e       mode_q, mode_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW:0]   count_inc;

  always_comb begin
    mode_d    = step_i ? next_mode(mode_q) : mode_q;
    count_inc = {1'b0, count_q} + {{CntW{1'b0}}, 1'b1};
    count_d   = count_q;
    level_o   = 1'b1;
    unique case (mode_d)
      MODE_SET:   level_o = 1'b1;
      MODE_RESET: level_o = 1'b0;
      default: begin
        count_d = (count_inc > {1'b0, cfg_i.period_max}) ? '0 : count_inc[CntW-1:0];
        level_o = !(count_d < cfg_i.low_ticks);
      end
    endcase
  end

  assign mode_o = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SET;
      count_q <= '0;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

### rtl/key_short_long_press_led_modes.sv
// Key debounce with short/long press detection driving two LED modes.
// The result for a tick is registered and appears in the cycle after its transfer.
// Throughput: one tick per cycle while the output is not stalled; the output register refills in the cycle it drains.
// Reset: async active low; config regs load 3000/1000/500, key machine idle,
// both LEDs in set mode, blink counters zero, output register empty.
// Depends on kslp_pkg, kslp_if, kslp_led.
`timescale 1ns / 1ps
`default_nettype none

module key_short_long_press_led_modes
  import kslp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CntW-1:0]    cfg_wdata_i,
  kslp_in_if.sink                 key_i,
  kslp_out_if.source              res_o
);

  // Configuration registers; writes to an unused index are dropped.
  logic [CntW-1:0] long_press_q;
  blink_cfg_t      blink_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q           <= LONG_PRESS_RST;
      blink_cfg_q.period_max <= BLINK_MAX_RST;
      blink_cfg_q.low_ticks  <= BLINK_LOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LONG_PRESS: long_press_q           <= cfg_wdata_i;
        CFG_BLINK_MAX:  blink_cfg_q.period_max <= cfg_wdata_i;
        CFG_BLINK_LOW:  blink_cfg_q.low_ticks  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: take a tick whenever the output slot is free or draining.
  logic out_valid_q;
  logic advance;

  assign key_i.ready = !out_valid_q || res_o.ready;
  assign advance     = key_i.valid && key_i.ready;

  // Key phase machine
  key_phase_e      phase_q, phase_d;
  logic [CntW-1:0] hold_q, hold_d;
  logic [CntW:0]   hold_inc;
  key_event_e      event_d;
  logic            pressed;

  assign pressed  = !key_i.key_level;
  assign hold_inc = {1'b0, hold_q} + {{CntW{1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hold_q  <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      hold_q  <= hold_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    hold_d  = hold_q;
    event_d = EV_NONE;
    unique case (phase_q)
      PH_IDLE: begin
        if (pressed) phase_d = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        // second low sample confirms the press
        if (pressed) begin
          hold_d  = '0;
          phase_d = PH_TIMING;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_TIMING: begin
        if (!pressed) begin
          event_d = EV_SHORT;
          phase_d = PH_IDLE;
        end else begin
          hold_d = hold_inc[CntW-1:0];
          // compare at full width so a zero threshold fires at once
          if (hold_inc >= {1'b0, long_press_q}) begin
            event_d = EV_LONG;
            phase_d = PH_WAIT;
          end
        end
      end
      default: begin
        if (!pressed) phase_d = PH_IDLE;
      end
    endcase
  end

  // LED channels: short press steps LED1, long press steps LED2.
  led_mode_e led1_mode, led2_mode;
  logic      led1_level, led2_level;

  kslp_led u_led1 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .step_i    (event_d == EV_SHORT),
    .cfg_i     (blink_cfg_q),
    .mode_o    (led1_mode),
    .level_o   (led1_level)
  );

  kslp_led u_led2 (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .step_i    (event_d == EV_LONG),
    .cfg_i     (blink_cfg_q),
    .mode_o    (led2_mode),
    .level_o   (led2_level)
  );

  // Output register
  logic [1:0] event_q;
  logic       led1_level_q, led2_level_q;
  logic [1:0] led1_mode_q, led2_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q      <= event_d;
      led1_level_q <= led1_level;
      led2_level_q <= led2_level;
      led1_mode_q  <= led1_mode;
      led2_mode_q  <= led2_mode;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.key_event  = event_q;
  assign res_o.led1_level = led1_level_q;
  assign res_o.led2_level = led2_level_q;
  assign res_o.led1_mode  = led1_mode_q;
  assign res_o.led2_mode  = led2_mode_q;

endmodule

`default_nettype wire

### test/key_short_long_press_led_modes_tb.sv
// Self-checking bench for key_short_long_press_led_modes: directed table, then random key traffic.
// Tick-by-tick predictor with per-transfer comparison. Needs kslp_pkg, kslp_if and the block.
`timescale 1ns / 1ps

module key_short_long_press_led_modes_tb;
  import kslp_pkg::*;

  // Index 3 maps to no register; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  localparam int DirRows = 24;
  localparam int PhaseCnt = 6;
  localparam int TicksPerPhase = 235;
  localparam int MaxReports = 10;

  typedef struct packed {
    key_event_e ev;
    logic       led1;
    logic       led2;
    led_mode_e  mode1;
    led_mode_e  mode2;
  } tick_res_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic               key;
    logic [CfgIdxW-1:0] idx;
    logic [CntW-1:0]    data;
    bit                 typed;  // want holds a hand-written result
    tick_res_t          want;
  } dir_row_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CntW-1:0]    cfg_wdata;

  kslp_in_if  key_ch ();
  kslp_out_if res_ch ();

  key_short_long_press_led_modes uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .key_i      (key_ch),
    .res_o      (res_ch)
  );

  // Predictor state: mirrors the block's registers and config.
  key_phase_e      pred_phase;
  logic [CntW-1:0] pred_hold;
  led_mode_e       pred_m1;
  led_mode_e       pred_m2;
  logic [CntW-1:0] pred_cnt1;
  logic [CntW-1:0] pred_cnt2;
  logic [CntW-1:0] cfg_long;
  logic [CntW-1:0] cfg_max;
  logic [CntW-1:0] cfg_low;

  // One entry per accepted key tick, oldest first.
  tick_res_t led_results_due[$];

  dir_row_t dir_tab [DirRows];

  int src_idle_pct;
  int snk_stall_pct;
  int stall_reqs;      // bumped by the stimulus to ask for a long output hold-off
  int mismatches;
  int ticks_sent;
  int results_seen;
  int short_seen;
  int long_seen;
  int reg_writes;

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Slowest legit run, with heavy idling plus the long output hold-off, ends
  // well inside this timeout, which leaves a wide margin.
  initial begin
    #400_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // set -> reset -> blink -> set
  function automatic led_mode_e mode_after(input led_mode_e m);
    case (m)
      MODE_SET:   return MODE_RESET;
      MODE_RESET: return MODE_BLINK;
      default:    return MODE_SET;
    endcase
  endfunction

  // Counter only moves in blink mode; 17-bit increment so 65535 wraps cleanly
  function automatic logic [CntW-1:0] blink_advance(input led_mode_e m,
                                                   input logic [CntW-1:0] cnt);
    logic [CntW:0] nxt;
    if (m != MODE_BLINK) return cnt;
    nxt = {1'b0, cnt} + 1'b1;
    if (nxt > {1'b0, cfg_max}) nxt = '0;
    return nxt[CntW-1:0];
  endfunction

  function automatic logic pin_level(input led_mode_e m, input logic [CntW-1:0] cnt);
    case (m)
      MODE_SET:   return 1'b1;
      MODE_RESET: return 1'b0;
      default:    return (cnt >= cfg_low);
    endcase
  endfunction

  // Advances the key machine and both LEDs by one tick; returns the result
  // the block should hand out for it.
  function automatic tick_res_t key_led_tick(input logic lvl);
    tick_res_t     r;
    logic [CntW:0] held;
    r.ev = EV_NONE;
    case (pred_phase)
      PH_IDLE: begin
        if (!lvl) pred_phase = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        if (!lvl) begin
          pred_hold = '0;
          pred_phase = PH_TIMING;
        end else begin
          pred_phase = PH_IDLE;
        end
      end
      PH_TIMING: begin
        if (lvl) begin
          r.ev = EV_SHORT;
          pred_phase = PH_IDLE;
        end else begin
          // compare at 17 bits, keep 16
          held = {1'b0, pred_hold} + 1'b1;
          pred_hold = held[CntW-1:0];
          if (held >= {1'b0, cfg_long}) begin
            r.ev = EV_LONG;
            pred_phase = PH_WAIT;
          end
        end
      end
      default: begin
        if (lvl) pred_phase = PH_IDLE;
      end
    endcase
    if (r.ev == EV_SHORT) pred_m1 = mode_after(pred_m1);
    else if (r.ev == EV_LONG) pred_m2 = mode_after(pred_m2);
    pred_cnt1 = blink_advance(pred_m1, pred_cnt1);
    pred_cnt2 = blink_advance(pred_m2, pred_cnt2);
    r.led1 = pin_level(pred_m1, pred_cnt1);
    r.led2 = pin_level(pred_m2, pred_cnt2);
    r.mode1 = pred_m1;
    r.mode2 = pred_m2;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic set_idling(input idle_mode_e m);
    case (m)
      IDLE_NONE: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      IDLE_SRC:  begin src_idle_pct = 70; snk_stall_pct = 0;  end
      IDLE_SNK:  begin src_idle_pct = 0;  snk_stall_pct = 70; end
      default:   begin src_idle_pct = 25; snk_stall_pct = 25; end
    endcase
  endtask

  // One key tick: random idle gap, then hold valid until the transfer.
  // valid is left high afterwards; the next call or the next config write
  // decides at the following falling edge.
  task automatic send_tick(input logic lvl);
    @(negedge clk);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      key_ch.valid <= 1'b0;
      @(negedge clk);
    end
    key_ch.valid <= 1'b1;
    key_ch.key_level <= lvl;
    do @(posedge clk); while (!(key_ch.valid === 1'b1 && key_ch.ready === 1'b1));
    led_results_due.push_back(key_led_tick(lvl));
    ticks_sent++;
  endtask

  // Register write only once every result has drained. Every tick yields a
  // result, so an empty queue means the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CntW-1:0] data);
    @(negedge clk);
    key_ch.valid <= 1'b0;
    while (led_results_due.size() != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LONG_PRESS: cfg_long = data;
      CFG_BLINK_MAX:  cfg_max = data;
      CFG_BLINK_LOW:  cfg_low = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Mostly complete presses (short or long against the current threshold),
  // plus single-sample bounces and raw noise.
  task automatic press_traffic(input int n);
    int stop_at;
    int pick;
    int lows;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        repeat ($urandom_range(3, 1)) send_tick(1'b1);
        // short needs at most threshold+1 low samples, long needs one more
        if ($urandom_range(1) == 0 && cfg_long != 0) lows = $urandom_range(cfg_long + 1, 2);
        else lows = cfg_long + 2 + $urandom_range(3);
        repeat (lows) send_tick(1'b0);
        send_tick(1'b1);
      end else if (pick < 85) begin
        send_tick(1'b0);
        send_tick(1'b1);
      end else begin
        repeat ($urandom_range(6, 1)) send_tick(1'($urandom_range(1)));
      end
    end
  endtask

  function automatic dir_row_t tick_row(input logic key, input bit typed, input tick_res_t want);
    dir_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.key = key;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                       input logic [CntW-1:0] data);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stalls plus a single long hold-off so the
  // output register fills and the input side has to back off.
  // ---------------------------------------------------------------------------
  initial begin : result_ready
    int hold_left;
    int stall_taken;
    hold_left = 0;
    stall_taken = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_taken != stall_reqs) begin
        stall_taken = stall_reqs;
        hold_left = 64;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    tick_res_t got;
    tick_res_t want;
    if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got = {res_ch.key_event, res_ch.led1_level, res_ch.led2_level,
             res_ch.led1_mode, res_ch.led2_mode};
      results_seen++;
      if (got.ev == EV_SHORT) short_seen++;
      if (got.ev == EV_LONG) long_seen++;
      if (led_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result ev=%0d led1=%b led2=%b mode1=%0d mode2=%0d",
                   $realtime, got.ev, got.led1, got.led2, got.mode1, got.mode2);
      end else begin
        want = led_results_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: result %0d exp ev=%0d l1=%b l2=%b m1=%0d m2=%0d, got ev=%0d l1=%b l2=%b m1=%0d m2=%0d",
                     $realtime, results_seen, want.ev, want.led1, want.led2, want.mode1,
                     want.mode2, got.ev, got.led1, got.led2, got.mode1, got.mode2);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [CntW-1:0] lp;
    logic [CntW-1:0] bm;
    logic [CntW-1:0] bl;

    // known values on every input from time zero
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_LONG_PRESS;
    cfg_wdata = '0;
    key_ch.valid = 1'b0;
    key_ch.key_level = 1'b1;
    stall_reqs = 0;
    mismatches = 0;
    ticks_sent = 0;
    results_seen = 0;
    short_seen = 0;
    long_seen = 0;
    reg_writes = 0;
    set_idling(IDLE_NONE);

    pred_phase = PH_IDLE;
    pred_hold = '0;
    pred_m1 = MODE_SET;
    pred_m2 = MODE_SET;
    pred_cnt1 = '0;
    pred_cnt2 = '0;
    cfg_long = LONG_PRESS_RST;
    cfg_max = BLINK_MAX_RST;
    cfg_low = BLINK_LOW_RST;

    // Directed table. First rows run on the reset config: glitch rejection,
    // debounce, a short press. Then zero threshold / zero period, the spare
    // index, and finally everything at 65535.
    dir_tab[0]  = tick_row(1'b1, 1, {EV_NONE, 1'b1, 1'b1, MODE_SET, MODE_SET});
    dir_tab[1]  = tick_row(1'b0, 1, {EV_NONE, 1'b1, 1'b1, MODE_SET, MODE_SET});
    dir_tab[2]  = tick_row(1'b1, 1, {EV_NONE, 1'b1, 1'b1, MODE_SET, MODE_SET});
    dir_tab[3]  = tick_row(1'b0, 1, {EV_NONE, 1'b1, 1'b1, MODE_SET, MODE_SET});
    dir_tab[4]  = tick_row(1'b0, 1, {EV_NONE, 1'b1, 1'b1, MODE_SET, MODE_SET});
    dir_tab[5]  = tick_row(1'b1, 1, {EV_SHORT, 1'b0, 1'b1, MODE_RESET, MODE_SET});
    dir_tab[6]  = tick_row(1'b0, 0, '0);
    dir_tab[7]  = tick_row(1'b0, 0, '0);
    dir_tab[8]  = tick_row(1'b1, 0, '0);  // LED1 into blink
    dir_tab[9]  = cfg_row(CFG_LONG_PRESS, 16'd0);
    dir_tab[10] = cfg_row(CFG_BLINK_MAX, 16'd0);
    dir_tab[11] = cfg_row(CFG_BLINK_LOW, 16'd0);
    dir_tab[12] = cfg_row(CfgIdxSpare, 16'hFFFF);
    dir_tab[13] = tick_row(1'b0, 0, '0);
    dir_tab[14] = tick_row(1'b0, 0, '0);
    // zero threshold: first low sample in timing is already a long press
    dir_tab[15] = tick_row(1'b0, 1, {EV_LONG, 1'b1, 1'b0, MODE_BLINK, MODE_RESET});
    dir_tab[16] = tick_row(1'b0, 0, '0);
    dir_tab[17] = tick_row(1'b1, 0, '0);
    dir_tab[18] = cfg_row(CFG_BLINK_MAX, 16'hFFFF);
    dir_tab[19] = cfg_row(CFG_BLINK_LOW, 16'hFFFF);
    dir_tab[20] = cfg_row(CFG_LONG_PRESS, 16'hFFFF);
    dir_tab[21] = tick_row(1'b0, 0, '0);
    dir_tab[22] = tick_row(1'b0, 0, '0);
    dir_tab[23] = tick_row(1'b1, 1, {EV_SHORT, 1'b1, 1'b0, MODE_SET, MODE_RESET});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DirRows; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_tick(dir_tab[i].key);
        if (dir_tab[i].typed) led_results_due[led_results_due.size()-1] = dir_tab[i].want;
      end
    end

    // Max threshold: a few hundred held ticks stay a short press.
    // LED1 blinks meanwhile with the max period and max low time.
    while (pred_m1 != MODE_BLINK) begin
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
    end
    repeat (200) send_tick(1'b0);
    send_tick(1'b1);

    // Random phases, each with its own register setting and one of the idling profiles
    for (int p = 0; p < PhaseCnt; p++) begin
      case (p)
        0: begin
          set_idling(IDLE_NONE);
          lp = 16'd1; bm = 16'd1; bl = 16'd0;
        end
        1: begin
          set_idling(IDLE_SRC);
          lp = 16'd4; bm = 16'd7; bl = 16'd3;
        end
        2: begin
          set_idling(IDLE_SNK);
          lp = 16'd12; bm = 16'd0; bl = 16'd1;
        end
        3: begin
          set_idling(IDLE_BOTH);
          lp = CntW'($urandom_range(30, 2));
          bm = CntW'($urandom_range(50, 1));
          bl = CntW'($urandom_range(bm + 1));
        end
        4: begin
          set_idling(IDLE_NONE);
          lp = 16'd30; bm = 16'hFFFF; bl = 16'd2;
        end
        default: begin
          set_idling(IDLE_BOTH);
          lp = 16'd3; bm = 16'd20; bl = 16'd20;
        end
      endcase
      write_reg(CFG_LONG_PRESS, lp);
      write_reg(CFG_BLINK_MAX, bm);
      write_reg(CFG_BLINK_LOW, bl);
      // back-pressure: output held off while input keeps offering
      if (p == 0) stall_reqs++;
      press_traffic(TicksPerPhase);
    end

    @(negedge clk);
    key_ch.valid <= 1'b0;
    while (led_results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);  // catch any stray result

    $display("Ran %0d key ticks through %0d register writes (zero and full-scale settings).",
             ticks_sent, reg_writes);
    $display("Checked %0d results: %0d short and %0d long presses, %0d mismatches.",
             results_seen, short_seen, long_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
